@@ src/route_fuel_range_estimator_defines.svh @@
// assertion macros for the route fuel range estimator
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef ROUTE_FUEL_RANGE_ESTIMATOR_DEFINES_SVH
`define ROUTE_FUEL_RANGE_ESTIMATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RFRE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RFRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rfre_pkg.sv @@
// package for the route fuel range estimator: widths, band table,
// sequencer program and helper functions; depends on nothing
package rfre_pkg;

    // field and state widths
    localparam int SPEED_BAND_COUNT = 13;
    localparam int DISTANCE_BITS    = 24;
    localparam int DIST_W   = DISTANCE_BITS;
    localparam int LEVEL_W  = 10;
    localparam int SPEED_W  = 16;
    localparam int OUT_W    = 16;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int BAND_W   = 7;
    localparam int NEED_W   = DIST_W + BAND_W;
    localparam int FUEL_W   = 48;
    localparam int ROUTE_W  = 32;
    localparam int BASE_W   = 8;
    localparam int THRESH_W = 8;
    localparam int DENOM_W  = 18;
    localparam int THR_W    = THRESH_W + DENOM_W;
    localparam int PROD_W   = ROUTE_W + BASE_W;
    localparam int DIV_W    = PROD_W + 2;
    localparam int DVS_W    = DENOM_W;
    localparam int CNT_W    = $clog2(DIV_W + 1);

    localparam longint UL_PER_LITRE = 1000000;
    localparam longint FUEL_MAX_VAL = ((longint'(1) << LEVEL_W) - 1) * UL_PER_LITRE;
    // fuel left never exceeds a full tank load, so its positive part is this narrow
    localparam int POS_W = $clog2(FUEL_MAX_VAL + 1);
    localparam int UL_W  = $clog2(UL_PER_LITRE + 1);
    localparam logic [UL_W-1:0] UL_PER_L = UL_W'(UL_PER_LITRE);
    localparam logic [9:0] DENOM_SCALE = 10'd1000;
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(63);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 2'd2;

    // speed band consumption table, 0.1 l/100 km
    localparam int RATE_N     = 13;
    localparam int RATE_IDX_W = $clog2(RATE_N);
    localparam int BIDX_W     = $clog2(SPEED_BAND_COUNT + 1);
    localparam logic [BAND_W-1:0] BAND_RATE [RATE_N] = '{
        7'd60, 7'd60, 7'd60, 7'd60, 7'd45, 7'd45, 7'd45,
        7'd55, 7'd55, 7'd70, 7'd70, 7'd70, 7'd70
    };

    // micro operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_LOAD,
        OP_ADD_DIST,
        OP_SUB_FUEL,
        OP_DIV_PART,
        OP_DIV_STEP,
        OP_ADD_QUOT,
        OP_PREP,
        OP_DIV_REM,
        OP_SAVE_REM,
        OP_EMIT
    } t_op;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_SKIP,
        C_FUEL_NONPOS,
        C_NEED_GT_FUEL,
        C_DIV_MORE,
        C_NOT_LAST,
        C_OUT_FULL
    } t_cond;

    typedef logic [3:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // program step addresses
    localparam t_pc STEP_IDLE     = 4'd0;
    localparam t_pc STEP_LOAD     = 4'd1;
    localparam t_pc STEP_FUEL_CHK = 4'd2;
    localparam t_pc STEP_NEED_CHK = 4'd3;
    localparam t_pc STEP_ADD_DIST = 4'd4;
    localparam t_pc STEP_SUB      = 4'd5;
    localparam t_pc STEP_PART     = 4'd6;
    localparam t_pc STEP_PART_DIV = 4'd7;
    localparam t_pc STEP_ADD_QUOT = 4'd8;
    localparam t_pc STEP_END      = 4'd9;
    localparam t_pc STEP_PREP     = 4'd10;
    localparam t_pc STEP_REM      = 4'd11;
    localparam t_pc STEP_REM_DIV  = 4'd12;
    localparam t_pc STEP_SAVE     = 4'd13;
    localparam t_pc STEP_ENH_DIV  = 4'd14;
    localparam t_pc STEP_EMIT     = 4'd15;

    // control store: taken jump goes to target, otherwise to the next step
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            STEP_IDLE:     w = '{OP_LATCH,    C_NO_INPUT,     STEP_IDLE};
            STEP_LOAD:     w = '{OP_LOAD,     C_SKIP,         STEP_END};
            STEP_FUEL_CHK: w = '{OP_NOP,      C_FUEL_NONPOS,  STEP_SUB};
            STEP_NEED_CHK: w = '{OP_NOP,      C_NEED_GT_FUEL, STEP_PART};
            STEP_ADD_DIST: w = '{OP_ADD_DIST, C_NEVER,        STEP_IDLE};
            STEP_SUB:      w = '{OP_SUB_FUEL, C_ALWAYS,       STEP_END};
            STEP_PART:     w = '{OP_DIV_PART, C_NEVER,        STEP_IDLE};
            STEP_PART_DIV: w = '{OP_DIV_STEP, C_DIV_MORE,     STEP_PART_DIV};
            STEP_ADD_QUOT: w = '{OP_ADD_QUOT, C_ALWAYS,       STEP_SUB};
            STEP_END:      w = '{OP_NOP,      C_NOT_LAST,     STEP_IDLE};
            STEP_PREP:     w = '{OP_PREP,     C_NEVER,        STEP_IDLE};
            STEP_REM:      w = '{OP_DIV_REM,  C_NEVER,        STEP_IDLE};
            STEP_REM_DIV:  w = '{OP_DIV_STEP, C_DIV_MORE,     STEP_REM_DIV};
            STEP_SAVE:     w = '{OP_SAVE_REM, C_NEVER,        STEP_IDLE};
            STEP_ENH_DIV:  w = '{OP_DIV_STEP, C_DIV_MORE,     STEP_ENH_DIV};
            // the last step wraps to idle once the result register is free
            STEP_EMIT:     w = '{OP_EMIT,     C_OUT_FULL,     STEP_EMIT};
        endcase
        return w;
    endfunction

    // speed to band consumption, speeds past the top band use the top band
    function automatic logic [BAND_W-1:0] band_for_speed(input logic [SPEED_W-1:0] speed);
        logic [BIDX_W-1:0] idx;
        idx = '0;
        for (int k = 1; k < SPEED_BAND_COUNT; k++) begin
            if (32'(speed) >= 32'(10 * k)) begin
                idx = BIDX_W'(k);
            end
        end
        if (32'(idx) > RATE_N - 1) begin
            idx = BIDX_W'(RATE_N - 1);
        end
        return BAND_RATE[RATE_IDX_W'(idx)];
    endfunction

    // clamp a quotient to the output width
    function automatic logic [OUT_W-1:0] sat_out(input logic [DIV_W-1:0] q);
        return (|q[DIV_W-1:OUT_W]) ? '1 : q[OUT_W-1:0];
    endfunction

endpackage

@@ src/route_fuel_range_estimator.sv @@
// route fuel range estimator top level: microcoded sequencer over a small
// datapath with a shared restoring divider; depends on rfre_pkg and the defines header
//
//  channel   direction  handshake                  payload
//  segment   in         i_seg_valid / o_seg_stall  first, level, distance, speed, last
//  result    out        o_res_valid / i_res_stall  enhanced range, remaining range, warning
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// a skipped segment jumps from the load step to the end step, one with no fuel left
// to the fuel subtract; a fully fueled one adds its distance first, a partly fueled
// one runs the fuel-over-band divide first; the last segment adds the two divides by
// 1000 * base consumption, all on the one shared divider.
// reset clears the sequencer, route state and registers to their defaults.
// a new segment is taken only at the idle step; a stalled result holds the
// sequencer at its last step, and segments wait in the meantime.
`include "route_fuel_range_estimator_defines.svh"

module route_fuel_range_estimator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [rfre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rfre_pkg::CFG_W-1:0]    i_cfg_data,
    // segment channel
    input  logic                          i_seg_valid,
    output logic                          o_seg_stall,
    input  logic                          i_first_segment,
    input  logic [rfre_pkg::LEVEL_W-1:0]  i_fuel_level_l,
    input  logic [rfre_pkg::DIST_W-1:0]   i_segment_distance_m,
    input  logic [rfre_pkg::SPEED_W-1:0]  i_segment_speed_kmh,
    input  logic                          i_last_segment,
    // result channel
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output logic [rfre_pkg::OUT_W-1:0]    o_enhanced_range_km,
    output logic [rfre_pkg::OUT_W-1:0]    o_remaining_range_km,
    output logic                          o_fuel_short_warning
);
    import rfre_pkg::*;

    localparam logic signed [FUEL_W:0] FUEL_MIN_EXT = -((FUEL_W + 1)'(1) <<< (FUEL_W - 1));
    localparam logic signed [FUEL_W-1:0] FUEL_MIN   = FUEL_W'(FUEL_MIN_EXT);
    localparam logic signed [FUEL_W-1:0] FUEL_MAX   = FUEL_W'(FUEL_MAX_VAL);

    // sequencer and configuration
    t_pc                  r_pc, n_pc;
    logic [THRESH_W-1:0]  r_thresh, n_thresh;
    logic                 r_enable, n_enable;
    logic [BASE_W-1:0]    r_base_cons, n_base_cons;

    // latched segment
    logic                 r_first, n_first;
    logic [LEVEL_W-1:0]   r_level, n_level;
    logic [DIST_W-1:0]    r_dist, n_dist;
    logic [SPEED_W-1:0]   r_speed, n_speed;
    logic                 r_last, n_last;

    // route state
    logic signed [FUEL_W-1:0] r_fuel, n_fuel;
    logic [ROUTE_W-1:0]   r_route, n_route;

    // datapath
    logic [BAND_W-1:0]    r_band, n_band;
    logic [NEED_W-1:0]    r_need, n_need;
    logic [DENOM_W-1:0]   r_denom, n_denom;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [THR_W-1:0]     r_thr, n_thr;
    logic [DIV_W-1:0]     r_num, n_num;

    // divider
    logic [DIV_W-1:0]     r_dq, n_dq;
    logic [DVS_W-1:0]     r_dr, n_dr;
    logic [DVS_W-1:0]     r_dvs, n_dvs;
    logic [CNT_W-1:0]     r_div_cnt, n_div_cnt;

    // result staging and output register
    logic [OUT_W-1:0]     r_rem_hold, n_rem_hold;
    logic                 r_warn_hold, n_warn_hold;
    logic                 r_res_valid, n_res_valid;
    logic [OUT_W-1:0]     r_enh, n_enh;
    logic [OUT_W-1:0]     r_rem, n_rem;
    logic                 r_warn, n_warn;

    t_uword               w_uw;
    logic                 w_seg_acc;
    logic                 w_out_free;
    logic                 w_jump;
    logic [BAND_W-1:0]    w_band;
    logic [BASE_W-1:0]    w_base;
    logic [ROUTE_W:0]     w_route_sum;
    logic [ROUTE_W-1:0]   w_route_add;
    logic signed [FUEL_W:0] w_diff;
    logic [DVS_W:0]       w_trial;
    logic [DVS_W:0]       w_sub;
    logic                 w_qbit;

    assign w_uw       = ucode(r_pc);
    assign w_seg_acc  = i_seg_valid && !o_seg_stall;
    assign w_out_free = !r_res_valid || !i_res_stall;
    assign w_band     = band_for_speed(r_speed);
    assign w_base     = (r_base_cons == '0) ? BASE_W'(1) : r_base_cons;

    // jump condition
    always_comb begin
        unique case (w_uw.cond)
            C_NEVER:        w_jump = 1'b0;
            C_ALWAYS:       w_jump = 1'b1;
            C_NO_INPUT:     w_jump = !w_seg_acc;
            C_SKIP:         w_jump = (r_dist == '0) || (r_speed == '0);
            C_FUEL_NONPOS:  w_jump = r_fuel[FUEL_W-1] || (r_fuel == '0);
            C_NEED_GT_FUEL: w_jump = $signed(FUEL_W'(r_need)) > r_fuel;
            C_DIV_MORE:     w_jump = r_div_cnt > CNT_W'(1);
            C_NOT_LAST:     w_jump = !r_last;
            C_OUT_FULL:     w_jump = !w_out_free;
            default:        w_jump = 1'b0;
        endcase
    end

    // saturating route add, operand picked by the micro op
    assign w_route_add = (w_uw.op == OP_ADD_QUOT) ? r_dq[ROUTE_W-1:0] : ROUTE_W'(r_dist);
    assign w_route_sum = {1'b0, r_route} + {1'b0, w_route_add};

    // fuel minus need in one extra bit
    assign w_diff = {r_fuel[FUEL_W-1], r_fuel} - $signed((FUEL_W + 1)'(r_need));

    // one restoring divide step
    assign w_trial = {r_dr, r_dq[DIV_W-1]};
    assign w_sub   = w_trial - {1'b0, r_dvs};
    assign w_qbit  = !w_sub[DVS_W];

    // next state
    always_comb begin
        n_pc        = w_jump ? w_uw.target : t_pc'(r_pc + 1'b1);
        n_thresh    = r_thresh;
        n_enable    = r_enable;
        n_base_cons = r_base_cons;
        n_first     = r_first;
        n_level     = r_level;
        n_dist      = r_dist;
        n_speed     = r_speed;
        n_last      = r_last;
        n_fuel      = r_fuel;
        n_route     = r_route;
        n_band      = r_band;
        n_need      = r_need;
        n_denom     = r_denom;
        n_pos       = r_pos;
        n_prod      = r_prod;
        n_thr       = r_thr;
        n_num       = r_num;
        n_dq        = r_dq;
        n_dr        = r_dr;
        n_dvs       = r_dvs;
        n_div_cnt   = r_div_cnt;
        n_rem_hold  = r_rem_hold;
        n_warn_hold = r_warn_hold;
        n_res_valid = r_res_valid && i_res_stall;
        n_enh       = r_enh;
        n_rem       = r_rem;
        n_warn      = r_warn;

        // configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: n_thresh    = i_cfg_data[THRESH_W-1:0];
                CFG_ENABLE:    n_enable    = i_cfg_data[0];
                CFG_BASE:      n_base_cons = i_cfg_data[BASE_W-1:0];
                default:       ;
            endcase
        end

        // datapath action of the current step
        unique case (w_uw.op)
            OP_NOP: ;
            OP_LATCH: begin
                if (w_seg_acc) begin
                    n_first = i_first_segment;
                    n_level = i_fuel_level_l;
                    n_dist  = i_segment_distance_m;
                    n_speed = i_segment_speed_kmh;
                    n_last  = i_last_segment;
                end
            end
            OP_LOAD: begin
                if (r_first) begin
                    n_fuel  = $signed(FUEL_W'(r_level * UL_PER_L));
                    n_route = '0;
                end
                n_band = w_band;
                n_need = NEED_W'(w_band * r_dist);
            end
            OP_ADD_DIST, OP_ADD_QUOT: begin
                n_route = w_route_sum[ROUTE_W] ? '1 : w_route_sum[ROUTE_W-1:0];
            end
            OP_SUB_FUEL: begin
                n_fuel = (w_diff < FUEL_MIN_EXT) ? FUEL_MIN : w_diff[FUEL_W-1:0];
            end
            OP_DIV_PART: begin
                // fuel only covers part of the segment; all of it is used
                n_need    = r_fuel[NEED_W-1:0];
                n_dq      = DIV_W'(r_fuel[NEED_W-1:0]);
                n_dr      = '0;
                n_dvs     = DVS_W'(r_band);
                n_div_cnt = CNT_W'(DIV_W);
            end
            OP_DIV_STEP: begin
                if (r_div_cnt != '0) begin
                    n_dr      = w_qbit ? w_sub[DVS_W-1:0] : w_trial[DVS_W-1:0];
                    n_dq      = {r_dq[DIV_W-2:0], w_qbit};
                    n_div_cnt = r_div_cnt - 1'b1;
                end
            end
            OP_PREP: begin
                n_denom = DENOM_W'(w_base * DENOM_SCALE);
                n_pos   = (r_fuel[FUEL_W-1] || (r_fuel == '0)) ? '0 : r_fuel[POS_W-1:0];
                n_prod  = PROD_W'(r_route * w_base);
            end
            OP_DIV_REM: begin
                n_thr     = THR_W'(r_thresh * r_denom);
                // half the divisor added for round half up
                n_num     = DIV_W'(r_prod) + DIV_W'(r_pos) + DIV_W'(r_denom >> 1);
                n_dq      = DIV_W'(r_pos);
                n_dr      = '0;
                n_dvs     = r_denom;
                n_div_cnt = CNT_W'(DIV_W);
            end
            OP_SAVE_REM: begin
                n_rem_hold  = sat_out(r_dq);
                n_warn_hold = r_enable && (r_fuel < $signed(FUEL_W'(r_thr)));
                n_dq        = r_num;
                n_dr        = '0;
                n_dvs       = r_denom;
                n_div_cnt   = CNT_W'(DIV_W);
            end
            OP_EMIT: begin
                if (w_out_free) begin
                    n_res_valid = 1'b1;
                    n_enh       = sat_out(r_dq);
                    n_rem       = r_rem_hold;
                    n_warn      = r_warn_hold;
                end
            end
            default: ;
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= STEP_IDLE;
            r_thresh    <= '0;
            r_enable    <= 1'b0;
            r_base_cons <= BASE_RESET;
            r_fuel      <= '0;
            r_route     <= '0;
            r_div_cnt   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_thresh    <= n_thresh;
            r_enable    <= n_enable;
            r_base_cons <= n_base_cons;
            r_fuel      <= n_fuel;
            r_route     <= n_route;
            r_div_cnt   <= n_div_cnt;
            r_res_valid <= n_res_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_first     <= n_first;
        r_level     <= n_level;
        r_dist      <= n_dist;
        r_speed     <= n_speed;
        r_last      <= n_last;
        r_band      <= n_band;
        r_need      <= n_need;
        r_denom     <= n_denom;
        r_pos       <= n_pos;
        r_prod      <= n_prod;
        r_thr       <= n_thr;
        r_num       <= n_num;
        r_dq        <= n_dq;
        r_dr        <= n_dr;
        r_dvs       <= n_dvs;
        r_rem_hold  <= n_rem_hold;
        r_warn_hold <= n_warn_hold;
        r_enh       <= n_enh;
        r_rem       <= n_rem;
        r_warn      <= n_warn;
    end

    assign o_seg_stall          = (r_pc != STEP_IDLE);
    assign o_res_valid          = r_res_valid;
    assign o_enhanced_range_km  = r_enh;
    assign o_remaining_range_km = r_rem;
    assign o_fuel_short_warning = r_warn;

    // checks on sequencer and datapath invariants
    `RFRE_ASSERT_NEXT(a_seg_starts_load, w_seg_acc, r_pc == STEP_LOAD, "segment not loaded")
    `RFRE_ASSERT_NOW(a_div_step_armed, w_uw.op == OP_DIV_STEP, r_div_cnt != '0, "divider idle in step")
    `RFRE_ASSERT_NOW(a_fuel_bounded, 1'b1, r_fuel <= FUEL_MAX, "fuel above full tank")

endmodule

@@ tb/route_fuel_range_estimator_test.sv @@
// testbench for route_fuel_range_estimator: directed and random route segments,
// checked against an in-bench range predictor; depends on rfre_pkg and the rtl
`timescale 1ns / 100ps

module route_fuel_range_estimator_test;
    import rfre_pkg::*;

    localparam int     QUIET_LIMIT  = 4000;
    localparam int     SETTLE_TICKS = 200;
    localparam longint FUEL_FLOOR   = -(longint'(1) << 47);
    localparam longint TRIP_CEIL    = 64'h0000_0000_FFFF_FFFF;
    localparam longint OUT_CEIL     = 65535;
    localparam int unsigned RATE_BY_BAND [13] = '{
        60, 60, 60, 60, 45, 45, 45, 55, 55, 70, 70, 70, 70
    };

    typedef struct packed {
        logic                first;
        logic [LEVEL_W-1:0]  level;
        logic [DIST_W-1:0]   seg_len;
        logic [SPEED_W-1:0]  speed;
        logic                last;
    } t_segment;

    typedef struct packed {
        logic [OUT_W-1:0] enhanced;
        logic [OUT_W-1:0] remaining;
        logic             warn;
    } t_range;

    // dut signals, all inputs known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_THRESHOLD;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_seg_valid = 1'b0;
    logic                  o_seg_stall;
    logic                  i_first_segment = 1'b0;
    logic [LEVEL_W-1:0]    i_fuel_level_l = '0;
    logic [DIST_W-1:0]     i_segment_distance_m = '0;
    logic [SPEED_W-1:0]    i_segment_speed_kmh = '0;
    logic                  i_last_segment = 1'b0;
    logic                  o_res_valid;
    logic                  i_res_stall = 1'b0;
    logic [OUT_W-1:0]      o_enhanced_range_km;
    logic [OUT_W-1:0]      o_remaining_range_km;
    logic                  o_fuel_short_warning;

    // predictor state and register copies
    longint      tank_ul = 0;
    longint      trip_m = 0;
    logic [7:0]  cfg_threshold = 8'd0;
    logic        cfg_advisor_on = 1'b0;
    logic [7:0]  cfg_base = BASE_RESET;

    t_range      range_q [$];
    t_range      want_r;
    int          failures = 0;
    int          seg_count = 0;
    int          quiet_cycles = 0;
    int          seg_idle_pct = 0;
    int          res_stall_pct = 0;

    route_fuel_range_estimator uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_seg_valid          (i_seg_valid),
        .o_seg_stall          (o_seg_stall),
        .i_first_segment      (i_first_segment),
        .i_fuel_level_l       (i_fuel_level_l),
        .i_segment_distance_m (i_segment_distance_m),
        .i_segment_speed_kmh  (i_segment_speed_kmh),
        .i_last_segment       (i_last_segment),
        .o_res_valid          (o_res_valid),
        .i_res_stall          (i_res_stall),
        .o_enhanced_range_km  (o_enhanced_range_km),
        .o_remaining_range_km (o_remaining_range_km),
        .o_fuel_short_warning (o_fuel_short_warning)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // consumption for a speed, clamped to the top band
    function automatic longint rate_for_speed(input logic [SPEED_W-1:0] speed);
        int unsigned s;
        int unsigned band;
        s = 32'(speed);
        if (s > SPEED_BAND_COUNT * 10 - 1) begin
            s = SPEED_BAND_COUNT * 10 - 1;
        end
        band = s / 10;
        if (band > 12) begin
            band = 12;
        end
        return longint'(RATE_BY_BAND[band]);
    endfunction

    // route distance grows up to the 32-bit ceiling
    function automatic longint grow_trip(input longint d);
        return (trip_m + d > TRIP_CEIL) ? TRIP_CEIL : trip_m + d;
    endfunction

    // advance the route state by one segment, give the range when the route ends
    function automatic bit estimate_range(input t_segment seg, output t_range res);
        longint rate;
        longint need;
        longint base;
        longint denom;
        longint pos;
        longint num;
        longint q;
        res = '0;
        if (seg.first) begin
            tank_ul = longint'(seg.level) * 1000000;
            trip_m  = 0;
        end
        if (seg.seg_len != 0 && seg.speed != 0) begin
            rate = rate_for_speed(seg.speed);
            need = rate * longint'(seg.seg_len);
            // only the part the fuel covers counts toward the route
            if (tank_ul > 0) begin
                if (need > tank_ul) begin
                    trip_m = grow_trip(tank_ul / rate);
                    need   = tank_ul;
                end else begin
                    trip_m = grow_trip(longint'(seg.seg_len));
                end
            end
            tank_ul = tank_ul - need;
            if (tank_ul < FUEL_FLOOR) begin
                tank_ul = FUEL_FLOOR;
            end
        end
        if (!seg.last) begin
            return 1'b0;
        end
        base  = (cfg_base == 0) ? 1 : longint'(cfg_base);
        denom = 1000 * base;
        pos   = (tank_ul > 0) ? tank_ul : 0;
        q = pos / denom;
        res.remaining = (q > OUT_CEIL) ? '1 : OUT_W'(q);
        // route km plus remaining km, rounded half up
        num = trip_m * base + pos;
        q = (2 * num + denom) / (2 * denom);
        res.enhanced = (q > OUT_CEIL) ? '1 : OUT_W'(q);
        res.warn = cfg_advisor_on && (tank_ul < longint'(cfg_threshold) * denom);
        return 1'b1;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (range_q.size() == 0) begin
                $error("result with no expectation: enhanced_range_km %0d",
                       o_enhanced_range_km);
                failures++;
            end else begin
                want_r = range_q.pop_front();
                if (o_enhanced_range_km !== want_r.enhanced) begin
                    $error("enhanced_range_km: expected %0d, got %0d",
                           want_r.enhanced, o_enhanced_range_km);
                    failures++;
                end
                if (o_remaining_range_km !== want_r.remaining) begin
                    $error("remaining_range_km: expected %0d, got %0d",
                           want_r.remaining, o_remaining_range_km);
                    failures++;
                end
                if (o_fuel_short_warning !== want_r.warn) begin
                    $error("fuel_short_warning: expected %0d, got %0d",
                           want_r.warn, o_fuel_short_warning);
                    failures++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_res_stall <= ($urandom_range(99, 0) < res_stall_pct);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_seg_valid && !o_seg_stall) || (o_res_valid && !i_res_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one segment transaction, with a random gap in front
    task automatic send_segment(input t_segment seg);
        t_range res;
        while ($urandom_range(99, 0) < seg_idle_pct) begin
            i_seg_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_seg_valid          <= 1'b1;
        i_first_segment      <= seg.first;
        i_fuel_level_l       <= seg.level;
        i_segment_distance_m <= seg.seg_len;
        i_segment_speed_kmh  <= seg.speed;
        i_last_segment       <= seg.last;
        @(posedge i_clk);
        while (o_seg_stall) begin
            @(posedge i_clk);
        end
        seg_count++;
        if (estimate_range(seg, res)) begin
            range_q.insert(range_q.size(), res);
        end
    endtask

    // stop sending, wait for every expected result, then let the block go quiet
    task automatic drain_results(input int extra);
        i_seg_valid <= 1'b0;
        @(posedge i_clk);
        while (range_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_THRESHOLD: cfg_threshold  = data;
            CFG_ENABLE:    cfg_advisor_on = data[0];
            CFG_BASE:      cfg_base       = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // all registers, written only once the block is idle
    task automatic set_config(input int thr, input bit en, input int base);
        drain_results(SETTLE_TICKS);
        write_reg(CFG_THRESHOLD, CFG_W'(thr));
        // upper bits of the enable write are don't-care
        write_reg(CFG_ENABLE, CFG_W'(($urandom & 32'hFE) | en));
        write_reg(CFG_BASE, CFG_W'(base));
    endtask

    function automatic t_segment make_seg(input bit first, input int level, input int seg_len,
                                          input int speed, input bit last);
        t_segment seg;
        seg.first   = first;
        seg.level   = LEVEL_W'(level);
        seg.seg_len = DIST_W'(seg_len);
        seg.speed   = SPEED_W'(speed);
        seg.last    = last;
        return seg;
    endfunction

    // well-formed segment content, biased toward band edges and running dry
    function automatic t_segment random_segment(input bit first, input bit last);
        t_segment seg;
        seg.first = first;
        seg.last  = last;
        case ($urandom_range(7, 0))
            0:       seg.level = '0;
            1:       seg.level = '1;
            2, 3:    seg.level = LEVEL_W'($urandom_range(20, 1));
            default: seg.level = LEVEL_W'($urandom);
        endcase
        case ($urandom_range(7, 0))
            0:       seg.seg_len = '0;
            1:       seg.seg_len = '1;
            2, 3:    seg.seg_len = DIST_W'($urandom_range(20000, 1));
            default: seg.seg_len = DIST_W'($urandom & ((32'd1 << $urandom_range(24, 1)) - 1));
        endcase
        case ($urandom_range(9, 0))
            0:       seg.speed = '0;
            1:       seg.speed = SPEED_W'($urandom);
            2:       seg.speed = SPEED_W'($urandom_range(135, 125));
            default: seg.speed = SPEED_W'($urandom_range(130, 1));
        endcase
        return seg;
    endfunction

    // a route of random length; an open one never gets its last segment
    task automatic send_route(input int max_len, input bit closed);
        int len;
        len = $urandom_range(max_len, 1);
        for (int k = 0; k < len; k++) begin
            send_segment(random_segment(k == 0, closed && (k == len - 1)));
        end
    endtask

    // extremes of the fields, skipped segments, band edges, no route started
    task automatic test_directed;
        int edges [10] = '{9, 10, 39, 40, 69, 70, 89, 90, 129, 130};
        set_config(255, 1'b1, 63);
        send_segment(make_seg(1'b0, 0, 1000, 50, 1'b1));
        send_segment(make_seg(1'b1, 1023, 32'h00FF_FFFF, 32'h0000_FFFF, 1'b0));
        send_segment(make_seg(1'b0, 0, 0, 100, 1'b0));
        send_segment(make_seg(1'b0, 0, 500, 0, 1'b1));
        send_segment(make_seg(1'b1, 0, 0, 0, 1'b1));
        for (int k = 0; k < 10; k++) begin
            send_segment(make_seg(k == 0, 1023, 1000, edges[k], k == 9));
        end
        send_segment(make_seg(1'b1, 1, 32'h00FF_FFFF, 1, 1'b1));
        send_segment(make_seg(1'b1, 1023, 1, 1, 1'b1));
        send_segment(make_seg(1'b1, 1023, 0, 0, 1'b1));
    endtask

    // register extremes, zero base consumption among them
    task automatic test_config_extremes;
        int thr_set  [6] = '{0, 255, 255, 0, 128, 17};
        bit en_set   [6] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        int base_set [6] = '{1, 1, 255, 0, 255, 63};
        int stop_at;
        for (int k = 0; k < 6; k++) begin
            set_config(thr_set[k], en_set[k], base_set[k]);
            stop_at = seg_count + 60;
            while (seg_count < stop_at) begin
                send_route(6, 1'b1);
            end
        end
    endtask

    // random routes with noise, open routes and a full drain now and then
    task automatic test_random_routes(input int seg_pct, input int res_pct, input int n_items);
        int stop_at;
        int next_pause;
        int pick;
        seg_idle_pct  = seg_pct;
        res_stall_pct = res_pct;
        set_config($urandom_range(255, 0), 1'($urandom_range(1, 0)), $urandom_range(255, 0));
        stop_at    = seg_count + n_items;
        next_pause = seg_count + 150;
        while (seg_count < stop_at) begin
            pick = $urandom_range(99, 0);
            if (pick < 12) begin
                send_segment(make_seg(1'($urandom_range(1, 0)), $urandom, $urandom,
                                      $urandom, 1'($urandom_range(1, 0))));
            end else begin
                send_route(8, pick >= 17);
            end
            if (seg_count >= next_pause) begin
                drain_results(0);
                next_pause += 150;
            end
        end
    endtask

    initial begin
        seg_idle_pct  = 24;
        res_stall_pct = 45;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_random_routes(24, 45, 525);
        test_random_routes(45, 24, 525);
        test_random_routes(0, 0, 525);

        drain_results(SETTLE_TICKS);
        if (failures == 0 && range_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
